[sv/wpmc_pkg.sv]
// wpmc_pkg: types and constants shared by the weighted pulse meter counter
// covers register index codes, configuration bundle and result item layout
// depends on nothing
`timescale 1ns / 1ps

package wpmc_pkg;

    localparam logic [31:0] UPGRADED_LIMIT  = 32'd12800;
    localparam logic [31:0] TIME_WRAP_POINT = 32'd4294967200;

    // result buffer depth, also the cap on items in the input stage and queue together
    localparam int unsigned OUT_DEPTH = 3;

    typedef enum logic [2:0] {
        CFG_WEIGHT_A    = 3'd0,
        CFG_WEIGHT_B    = 3'd1,
        CFG_WEIGHT_C    = 3'd2,
        CFG_INIT_LIMIT  = 3'd3,
        CFG_UPGRADE_T   = 3'd4,
        CFG_BLINK_STEP  = 3'd5,
        CFG_LED_ON      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] weight_phase_a;
        logic [15:0] weight_phase_b;
        logic [15:0] weight_phase_c;
        logic [31:0] initial_limit;
        logic [31:0] upgrade_time;
        logic [7:0]  blinks_per_step;
        logic [31:0] led_on_ticks;
    } wpmc_cfg_t;

    typedef struct packed {
        logic        led_lit;
        logic        coil_phase;
        logic        coil_stepped;
        logic [31:0] pulse_total;
    } wpmc_result_t;

endpackage

[sv/wpmc_core.sv]
// wpmc_core: meter state and the single-pass update for one registered item
// depends on wpmc_pkg
`timescale 1ns / 1ps

module wpmc_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wpmc_pkg::wpmc_cfg_t     cfg,
    input  logic                    item_vld,
    input  logic                    item_kind,
    input  logic [2:0]              item_lines,
    output wpmc_pkg::wpmc_result_t  result
);

    logic [31:0] tick_time_reg,      tick_time_next;
    logic [31:0] accumulator_reg,    accumulator_next;
    logic [2:0]  last_active_reg,    last_active_next;
    logic        led_state_reg,      led_state_next;
    logic [31:0] led_start_time_reg, led_start_time_next;
    logic [7:0]  blink_count_reg,    blink_count_next;
    logic        coil_state_reg,     coil_state_next;
    logic        upgraded_reg,       upgraded_next;

    logic [2:0]  active;
    logic [2:0]  fresh;
    logic [17:0] weight_sum;
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;
    logic [31:0] limit;
    logic        blink;
    logic        stepped;
    logic [31:0] time_inc;
    logic [7:0]  blink_inc;
    logic        led_mid;

    always_comb
    begin
        active     = ~item_lines;
        fresh      = active & ~last_active_reg;
        // saturation is monotonic, so one add of the summed weights matches
        // three saturating adds in turn
        weight_sum = (fresh[2] ? {2'b00, cfg.weight_phase_a} : 18'd0)
                   + (fresh[1] ? {2'b00, cfg.weight_phase_b} : 18'd0)
                   + (fresh[0] ? {2'b00, cfg.weight_phase_c} : 18'd0);
        acc_sum    = {1'b0, accumulator_reg} + {15'd0, weight_sum};
        acc_sat    = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        limit      = upgraded_reg ? wpmc_pkg::UPGRADED_LIMIT : cfg.initial_limit;

        blink      = !item_kind && (acc_sat >= limit);
        time_inc   = item_kind ? tick_time_reg + 32'd1 : tick_time_reg;
        blink_inc  = blink_count_reg + 8'd1;

        accumulator_next    = accumulator_reg;
        last_active_next    = last_active_reg;
        led_start_time_next = led_start_time_reg;
        blink_count_next    = blink_count_reg;
        coil_state_next     = coil_state_reg;
        stepped             = 1'b0;

        if (!item_kind)
        begin
            accumulator_next = blink ? 32'd0 : acc_sat;
            last_active_next = active;
        end

        if (blink)
        begin
            led_start_time_next = time_inc;
            blink_count_next    = blink_inc;
            if (blink_inc == cfg.blinks_per_step)
            begin
                coil_state_next  = ~coil_state_reg;
                stepped          = 1'b1;
                blink_count_next = 8'd0;
            end
        end

        led_mid        = led_state_reg | blink;
        led_state_next = led_mid
                       && ((time_inc - led_start_time_next) < cfg.led_on_ticks);

        tick_time_next = (time_inc > wpmc_pkg::TIME_WRAP_POINT) ? 32'd0 : time_inc;
        upgraded_next  = upgraded_reg || (tick_time_next > cfg.upgrade_time);

        result.led_lit      = led_state_next;
        result.coil_phase   = coil_state_next;
        result.coil_stepped = stepped;
        result.pulse_total  = accumulator_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg      <= 32'd0;
            accumulator_reg    <= 32'd0;
            last_active_reg    <= 3'd0;
            led_state_reg      <= 1'b0;
            led_start_time_reg <= 32'd0;
            blink_count_reg    <= 8'd0;
            coil_state_reg     <= 1'b0;
            upgraded_reg       <= 1'b0;
        end
        else if (item_vld)
        begin
            tick_time_reg      <= tick_time_next;
            accumulator_reg    <= accumulator_next;
            last_active_reg    <= last_active_next;
            led_state_reg      <= led_state_next;
            led_start_time_reg <= led_start_time_next;
            blink_count_reg    <= blink_count_next;
            coil_state_reg     <= coil_state_next;
            upgraded_reg       <= upgraded_next;
        end
    end

endmodule

[sv/wpmc_out_buf.sv]
// wpmc_out_buf: small result queue that decouples output stall from input
// depends on wpmc_pkg
`timescale 1ns / 1ps

module wpmc_out_buf
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  wpmc_pkg::wpmc_result_t  push_data,
    input  logic                    pop,
    output logic                    not_empty,
    output logic [1:0]              count,
    output wpmc_pkg::wpmc_result_t  head
);

    localparam int unsigned PTR_W = $clog2(wpmc_pkg::OUT_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(wpmc_pkg::OUT_DEPTH - 1);

    wpmc_pkg::wpmc_result_t mem [wpmc_pkg::OUT_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;

endmodule

[sv/weighted_pulse_meter_counter_top.sv]
// weighted_pulse_meter_counter_top: energy-meter pulse counter top level
// holds configuration registers, input stage and result queue
// depends on wpmc_pkg, wpmc_core, wpmc_out_buf
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------
// input     | in_valid / in_stall    | kind, phase_lines
// result    | out_valid / out_stall  | led_lit, coil_phase, coil_stepped, pulse_total
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each item is registered
// in the input stage, where the meter state updates in a single pass, then its
// result waits in a three-entry result queue
// in_stall is driven from registers only: it is high while the input stage plus
// the queue hold three results, so output stall never reaches the input
// combinationally
// reset (rst_n, asynchronous, active low) restores the configuration, valid and
// pointer registers and the meter state, not payload data; cfg_ready is always high

module weighted_pulse_meter_counter_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [2:0]  phase_lines,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        led_lit,
    output logic        coil_phase,
    output logic        coil_stepped,
    output logic [31:0] pulse_total,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wpmc_pkg::wpmc_cfg_t    cfg_reg;
    wpmc_pkg::wpmc_result_t core_result;
    wpmc_pkg::wpmc_result_t head;

    logic       in_vld_reg;
    logic       kind_reg;
    logic [2:0] lines_reg;
    logic       in_xfer;
    logic       out_xfer;
    logic       buf_not_empty;
    logic [1:0] buf_count;
    logic [2:0] in_flight;

    // configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_phase_a  <= 16'd1;
            cfg_reg.weight_phase_b  <= 16'd1;
            cfg_reg.weight_phase_c  <= 16'd1;
            cfg_reg.initial_limit   <= 32'd12800;
            cfg_reg.upgrade_time    <= 32'hFFFF_FFFF;
            cfg_reg.blinks_per_step <= 8'd10;
            cfg_reg.led_on_ticks    <= 32'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // an index past the last register leaves everything alone
            unique case (cfg_index)
                wpmc_pkg::CFG_WEIGHT_A:   cfg_reg.weight_phase_a  <= cfg_data[15:0];
                wpmc_pkg::CFG_WEIGHT_B:   cfg_reg.weight_phase_b  <= cfg_data[15:0];
                wpmc_pkg::CFG_WEIGHT_C:   cfg_reg.weight_phase_c  <= cfg_data[15:0];
                wpmc_pkg::CFG_INIT_LIMIT: cfg_reg.initial_limit   <= cfg_data;
                wpmc_pkg::CFG_UPGRADE_T:  cfg_reg.upgrade_time    <= cfg_data;
                wpmc_pkg::CFG_BLINK_STEP: cfg_reg.blinks_per_step <= cfg_data[7:0];
                wpmc_pkg::CFG_LED_ON:     cfg_reg.led_on_ticks    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // credit check: input stage plus queue never exceed the queue depth
    assign in_flight = {1'b0, buf_count} + {2'b00, in_vld_reg};
    assign in_stall  = (in_flight >= 3'(wpmc_pkg::OUT_DEPTH));
    assign in_xfer   = in_valid && !in_stall;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg  <= kind;
            lines_reg <= phase_lines;
        end
    end

    // meter state update, one item per cycle while the input stage holds one
    wpmc_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_vld   (in_vld_reg),
        .item_kind  (kind_reg),
        .item_lines (lines_reg),
        .result     (core_result)
    );

    // result queue; space is guaranteed by the credit check above
    assign out_xfer = out_valid && !out_stall;

    wpmc_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_vld_reg),
        .push_data  (core_result),
        .pop        (out_xfer),
        .not_empty  (buf_not_empty),
        .count      (buf_count),
        .head       (head)
    );

    assign out_valid    = buf_not_empty;
    assign led_lit      = head.led_lit;
    assign coil_phase   = head.coil_phase;
    assign coil_stepped = head.coil_stepped;
    assign pulse_total  = head.pulse_total;

endmodule

[verif/weighted_pulse_meter_counter_top_tb.sv]
// weighted_pulse_meter_counter_top_tb: self-checking bench for the pulse meter counter top
// a clocked driver feeds phase samples and timer ticks from a queue and a clocked monitor
// checks every result against a bit-exact meter model; depends on wpmc_pkg and the top
`timescale 1ns / 1ps

module weighted_pulse_meter_counter_top_tb;

    // item kinds and the register index the block has no register behind
    localparam logic       KIND_SAMPLE     = 1'b0;
    localparam logic       KIND_TICK       = 1'b1;
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;
    // length of the one long receiver hold-off, long enough to fill the block
    localparam int unsigned HOLD_CYCLES    = 60;

    typedef struct packed {
        logic       kind;
        logic [2:0] lines;
    } meter_item_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        kind        = 1'b0;
    logic [2:0]  phase_lines = 3'b111;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        led_lit;
    logic        coil_phase;
    logic        coil_stepped;
    logic [31:0] pulse_total;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index   = 3'd0;
    logic [31:0] cfg_data    = 32'd0;

    weighted_pulse_meter_counter_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .phase_lines  (phase_lines),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_lit      (led_lit),
        .coil_phase   (coil_phase),
        .coil_stepped (coil_stepped),
        .pulse_total  (pulse_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // meter model: its own copy of the registers and of the meter state
    // ------------------------------------------------------------------
    wpmc_pkg::wpmc_cfg_t meter_cfg =
        '{16'd1, 16'd1, 16'd1, 32'd12800, 32'hFFFF_FFFF, 8'd10, 32'd100};
    logic [31:0] meter_time      = '0;
    logic [31:0] meter_acc       = '0;
    logic [2:0]  meter_active    = '0;
    logic        meter_led       = 1'b0;
    logic [31:0] meter_led_start = '0;
    logic [7:0]  meter_blinks    = '0;
    logic        meter_coil      = 1'b0;
    logic        meter_upgraded  = 1'b0;

    meter_item_t            pending_items[$];     // items still to be offered
    wpmc_pkg::wpmc_result_t expected_results[$];  // results owed by the block, oldest first
    int unsigned            mismatch_count = 0;

    // idling controls, set per phase by the stimulus
    bit          send_idles = 1'b0;
    bit          recv_idles = 1'b0;
    bit          hold_req   = 1'b0;
    bit          in_taken   = 1'b0;
    int unsigned idle_left  = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;

    // saturating add of one phase weight
    function automatic logic [31:0] sat_add(logic [31:0] total, logic [15:0] weight);
        logic [32:0] sum;
        sum = {1'b0, total} + {17'd0, weight};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // advance the meter by one item and give the result it should produce
    function automatic wpmc_pkg::wpmc_result_t meter_step(logic item_kind, logic [2:0] lines);
        logic [2:0]             active;
        logic [2:0]             fresh;
        logic [31:0]            limit;
        logic [31:0]            elapsed;
        logic                   blink;
        logic                   stepped;
        wpmc_pkg::wpmc_result_t res;
        blink   = 1'b0;
        stepped = 1'b0;
        if (item_kind == KIND_SAMPLE)
        begin
            // lines are active low; only phases that were idle last sample count
            active = ~lines;
            fresh  = active & ~meter_active;
            limit  = meter_upgraded ? wpmc_pkg::UPGRADED_LIMIT : meter_cfg.initial_limit;
            if (fresh[2])
                meter_acc = sat_add(meter_acc, meter_cfg.weight_phase_a);
            if (fresh[1])
                meter_acc = sat_add(meter_acc, meter_cfg.weight_phase_b);
            if (fresh[0])
                meter_acc = sat_add(meter_acc, meter_cfg.weight_phase_c);
            if (meter_acc >= limit)
            begin
                meter_led = 1'b1;
                meter_acc = '0;
                blink     = 1'b1;
            end
            meter_active = active;
        end
        else
            meter_time = meter_time + 32'd1;

        if (blink)
        begin
            meter_led_start = meter_time;
            meter_blinks    = meter_blinks + 8'd1;
            if (meter_blinks == meter_cfg.blinks_per_step)
            begin
                meter_coil   = ~meter_coil;
                stepped      = 1'b1;
                meter_blinks = '0;
            end
        end

        elapsed = meter_time - meter_led_start;
        if (meter_led && elapsed >= meter_cfg.led_on_ticks)
            meter_led = 1'b0;
        if (meter_time > wpmc_pkg::TIME_WRAP_POINT)
            meter_time = '0;
        // upgrade is looked at after the wrap, and it is permanent
        if (meter_time > meter_cfg.upgrade_time)
            meter_upgraded = 1'b1;

        res.led_lit      = meter_led;
        res.coil_phase   = meter_coil;
        res.coil_stepped = stepped;
        res.pulse_total  = meter_acc;
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic meter_item_t random_item(int unsigned tick_pct);
        meter_item_t item;
        item.kind  = ($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_SAMPLE;
        item.lines = 3'($urandom);
        return item;
    endfunction

    task automatic offer(logic item_kind, logic [2:0] lines);
        meter_item_t item;
        item.kind  = item_kind;
        item.lines = lines;
        pending_items.push_back(item);
    endtask

    // register write; the model copy follows the write at its transfer edge
    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            wpmc_pkg::CFG_WEIGHT_A:   meter_cfg.weight_phase_a  = data[15:0];
            wpmc_pkg::CFG_WEIGHT_B:   meter_cfg.weight_phase_b  = data[15:0];
            wpmc_pkg::CFG_WEIGHT_C:   meter_cfg.weight_phase_c  = data[15:0];
            wpmc_pkg::CFG_INIT_LIMIT: meter_cfg.initial_limit   = data;
            wpmc_pkg::CFG_UPGRADE_T:  meter_cfg.upgrade_time    = data;
            wpmc_pkg::CFG_BLINK_STEP: meter_cfg.blinks_per_step = data[7:0];
            wpmc_pkg::CFG_LED_ON:     meter_cfg.led_on_ticks    = data;
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is in and every result is out, then let the
    // pipe settle before anything else happens
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // a transfer on the input channel: predict its result right here
    always @(posedge clk)
    begin : accept_watch
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(meter_step(kind, phase_lines));
            in_taken = 1'b1;
        end
    end

    // driver: a payload stays put until its transfer, then an optional gap
    always @(negedge clk)
    begin : item_driver
        meter_item_t item;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (idle_left != 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item = pending_items.pop_front();
                kind        <= item.kind;
                phase_lines <= item.lines;
                in_valid    <= 1'b1;
                idle_left   = pick_gap(send_idles);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver stall: random gaps, plus one long counted hold-off on request
    always @(negedge clk)
    begin : result_stall
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = pick_gap(recv_idles);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: each result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        wpmc_pkg::wpmc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("led_lit", 32'(want.led_lit), 32'(led_lit));
                check_field("coil_phase", 32'(want.coil_phase), 32'(coil_phase));
                check_field("coil_stepped", 32'(want.coil_stepped), 32'(coil_stepped));
                check_field("pulse_total", want.pulse_total, pulse_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        logic [31:0] value;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: simultaneous edges, single phases, ticks with any lines
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b000);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b011);
        offer(KIND_SAMPLE, 3'b101);
        offer(KIND_SAMPLE, 3'b110);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_TICK,   3'b000);
        offer(KIND_TICK,   3'b111);
        drain();

        // small weights with junk in the upper bits, short limit, fast coil,
        // short led on-time; the spare index must change nothing
        write_reg(wpmc_pkg::CFG_WEIGHT_A,    {16'hA5A5, 16'd5});
        write_reg(wpmc_pkg::CFG_WEIGHT_B,    {16'h5A5A, 16'd7});
        write_reg(wpmc_pkg::CFG_WEIGHT_C,    {16'hFFFF, 16'd11});
        write_reg(wpmc_pkg::CFG_INIT_LIMIT,  32'd20);
        write_reg(wpmc_pkg::CFG_BLINK_STEP,  {24'hFFFFFF, 8'd2});
        write_reg(wpmc_pkg::CFG_LED_ON,      32'd3);
        write_reg(CFG_SPARE_INDEX,           32'hFFFF_FFFF);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b000);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b000);
        offer(KIND_TICK,   3'b010);
        offer(KIND_TICK,   3'b101);
        offer(KIND_TICK,   3'b000);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b110);
        offer(KIND_SAMPLE, 3'b111);
        offer(KIND_SAMPLE, 3'b101);
        drain();

        // lower the limit under what is already held: a sample with no new
        // edge must still blink
        write_reg(wpmc_pkg::CFG_INIT_LIMIT, 32'd1);
        offer(KIND_SAMPLE, 3'b101);
        drain();

        // random phases, each under fresh settings drawn partly from the extremes
        for (phase = 0; phase < 7; phase++)
        begin
            send_idles = (phase != 3) && (phase != 5);
            recv_idles = (phase != 4);
            case ($urandom_range(0, 4))
                0:       value = 32'd0;
                1:       value = 32'd65535;
                4:       value = $urandom;
                default: value = $urandom_range(1, 40);
            endcase
            write_reg(wpmc_pkg::CFG_WEIGHT_A, {16'($urandom), value[15:0]});
            case ($urandom_range(0, 4))
                0:       value = 32'd0;
                1:       value = 32'd65535;
                4:       value = $urandom;
                default: value = $urandom_range(1, 40);
            endcase
            write_reg(wpmc_pkg::CFG_WEIGHT_B, {16'($urandom), value[15:0]});
            case ($urandom_range(0, 4))
                0:       value = 32'd0;
                1:       value = 32'd65535;
                4:       value = $urandom;
                default: value = $urandom_range(1, 40);
            endcase
            write_reg(wpmc_pkg::CFG_WEIGHT_C, {16'($urandom), value[15:0]});
            case ($urandom_range(0, 5))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = wpmc_pkg::UPGRADED_LIMIT;
                default: value = $urandom_range(1, 150);
            endcase
            write_reg(wpmc_pkg::CFG_INIT_LIMIT, value);
            // upgrade point kept out of reach until the dedicated phase
            case ($urandom_range(0, 2))
                0:       value = 32'hFFFF_FFFF;
                1:       value = wpmc_pkg::TIME_WRAP_POINT;
                default: value = $urandom_range(32'h8000_0000, 32'hFFFF_FFFE);
            endcase
            write_reg(wpmc_pkg::CFG_UPGRADE_T, value);
            case ($urandom_range(0, 4))
                0:       value = 32'd0;
                1:       value = 32'd1;
                2:       value = 32'd255;
                default: value = $urandom_range(2, 6);
            endcase
            write_reg(wpmc_pkg::CFG_BLINK_STEP, {24'($urandom), value[7:0]});
            case ($urandom_range(0, 3))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom_range(1, 12);
            endcase
            write_reg(wpmc_pkg::CFG_LED_ON, value);
            repeat (50) pending_items.push_back(random_item(30));
            // back-pressure: the receiver holds off while the sender keeps offering
            if (phase == 3)
                hold_req = 1'b1;
            drain();
        end

        // zero limit, zero blink step, zero on-time, zero weights: every sample
        // blinks, the lamp never stays lit, and the coil steps every 256 blinks
        send_idles = 1'b1;
        recv_idles = 1'b1;
        write_reg(wpmc_pkg::CFG_WEIGHT_A,   32'd0);
        write_reg(wpmc_pkg::CFG_WEIGHT_B,   32'd0);
        write_reg(wpmc_pkg::CFG_WEIGHT_C,   32'd0);
        write_reg(wpmc_pkg::CFG_INIT_LIMIT, 32'd0);
        write_reg(wpmc_pkg::CFG_BLINK_STEP, 32'd0);
        write_reg(wpmc_pkg::CFG_LED_ON,     32'd0);
        repeat (270) pending_items.push_back(random_item(0));
        drain();

        // full weights on all phases against a limit of four full samples, so
        // the running sum lands exactly on the limit
        send_idles = 1'b0;
        recv_idles = 1'b0;
        write_reg(wpmc_pkg::CFG_WEIGHT_A,   32'd65535);
        write_reg(wpmc_pkg::CFG_WEIGHT_B,   32'd65535);
        write_reg(wpmc_pkg::CFG_WEIGHT_C,   32'd65535);
        write_reg(wpmc_pkg::CFG_INIT_LIMIT, 32'd786420);
        write_reg(wpmc_pkg::CFG_BLINK_STEP, 32'd1);
        write_reg(wpmc_pkg::CFG_LED_ON,     32'hFFFF_FFFF);
        repeat (20)
        begin
            offer(KIND_SAMPLE, 3'b000);
            offer(KIND_SAMPLE, 3'b111);
        end
        drain();

        // upgrade: the initial limit is never reached, so every blink after
        // the upgrade point comes from the fixed upgraded limit
        send_idles = 1'b1;
        recv_idles = 1'b1;
        write_reg(wpmc_pkg::CFG_WEIGHT_A,   $urandom_range(1500, 5000));
        write_reg(wpmc_pkg::CFG_WEIGHT_B,   $urandom_range(1500, 5000));
        write_reg(wpmc_pkg::CFG_WEIGHT_C,   $urandom_range(1500, 5000));
        write_reg(wpmc_pkg::CFG_INIT_LIMIT, 32'hFFFF_FFFF);
        write_reg(wpmc_pkg::CFG_BLINK_STEP, $urandom_range(1, 3));
        write_reg(wpmc_pkg::CFG_LED_ON,     32'd4);
        write_reg(wpmc_pkg::CFG_UPGRADE_T,  meter_time + 32'd20);
        repeat (120) pending_items.push_back(random_item(40));
        drain();

        // once upgraded, neither the initial limit nor the upgrade point matter
        write_reg(wpmc_pkg::CFG_INIT_LIMIT, 32'd1);
        write_reg(wpmc_pkg::CFG_UPGRADE_T,  32'hFFFF_FFFF);
        repeat (60) pending_items.push_back(random_item(30));
        drain();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/wpmc_pkg.sv
sv/wpmc_core.sv
sv/wpmc_out_buf.sv
sv/weighted_pulse_meter_counter_top.sv
verif/weighted_pulse_meter_counter_top_tb.sv
